// File: rtl/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg
// Shared types, register addresses and command codes of the timer/TOD unit.
// ----------------------------------------------------------------------------
package cia_pkg;

  typedef enum logic [2:0] {
    CMD_READ   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_TIMER  = 3'd2,
    CMD_TOD    = 3'd3,
    CMD_FLAG   = 3'd4,
    CMD_SERIAL = 3'd5,
    CMD_RSV6   = 3'd6,
    CMD_RSV7   = 3'd7
  } cmd_e;

  localparam logic [3:0] ADDR_PA   = 4'd0;
  localparam logic [3:0] ADDR_PB   = 4'd1;
  localparam logic [3:0] ADDR_DA   = 4'd2;
  localparam logic [3:0] ADDR_DB   = 4'd3;
  localparam logic [3:0] ADDR_TAL  = 4'd4;
  localparam logic [3:0] ADDR_TAH  = 4'd5;
  localparam logic [3:0] ADDR_TBL  = 4'd6;
  localparam logic [3:0] ADDR_TBH  = 4'd7;
  localparam logic [3:0] ADDR_TD0  = 4'd8;
  localparam logic [3:0] ADDR_TD1  = 4'd9;
  localparam logic [3:0] ADDR_TD2  = 4'd10;
  localparam logic [3:0] ADDR_SDAT = 4'd12;
  localparam logic [3:0] ADDR_ISR  = 4'd13;
  localparam logic [3:0] ADDR_CA   = 4'd14;
  localparam logic [3:0] ADDR_CB   = 4'd15;

  localparam logic [7:0] CTRL_RESET = 8'h04;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] reg_addr;
    logic [7:0] wdata;
  } in_item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
  } out_item_t;

endpackage

// File: rtl/cia_core.sv
// ----------------------------------------------------------------------------
// cia_core
// Register file and single-pass update of timers, TOD and interrupt status.
// ----------------------------------------------------------------------------
module cia_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  cia_pkg::in_item_t item_i,
  output cia_pkg::out_item_t res_o
);
  import cia_pkg::*;

  logic [7:0]  port_a_q, port_b_q, dir_a_q, dir_b_q, sdat_q, isr_q, ctrl_a_q, ctrl_b_q;
  logic [7:0]  port_a_d, port_b_d, dir_a_d, dir_b_d, sdat_d, isr_d, ctrl_a_d, ctrl_b_d;
  logic [15:0] cnt_a_q, cnt_b_q, rel_a_q, rel_b_q, cnt_a_d, cnt_b_d, rel_a_d, rel_b_d;
  logic [23:0] tod_q, snap_q, alarm_q, tod_d, snap_d, alarm_d;
  logic        held_q, run_q, held_d, run_d;
  logic [6:0]  ien_q, ien_d;

  // Compute the next state and read data for one item
  always_comb begin
    logic        und_a, und_b;
    logic [23:0] tsel, tinc;
    logic [6:0]  setb;
    logic [7:0]  rd;
    port_a_d = port_a_q; port_b_d = port_b_q; dir_a_d = dir_a_q; dir_b_d = dir_b_q;
    sdat_d = sdat_q; isr_d = isr_q; ctrl_a_d = ctrl_a_q; ctrl_b_d = ctrl_b_q;
    cnt_a_d = cnt_a_q; cnt_b_d = cnt_b_q; rel_a_d = rel_a_q; rel_b_d = rel_b_q;
    tod_d = tod_q; snap_d = snap_q; alarm_d = alarm_q; held_d = held_q; run_d = run_q;
    ien_d = ien_q;
    und_a = 1'b0; und_b = 1'b0; setb = '0; rd = '0;
    tsel = held_q ? snap_q : tod_q;
    tinc = tod_q + 24'd1;
    case (cmd_e'(item_i.cmd))
      CMD_READ: begin
        case (item_i.reg_addr)
          ADDR_PA:   rd = port_a_q;
          ADDR_PB:   rd = port_b_q;
          ADDR_DA:   rd = dir_a_q;
          ADDR_DB:   rd = dir_b_q;
          ADDR_TAL:  rd = cnt_a_q[7:0];
          ADDR_TAH:  rd = cnt_a_q[15:8];
          ADDR_TBL:  rd = cnt_b_q[7:0];
          ADDR_TBH:  rd = cnt_b_q[15:8];
          ADDR_TD0:  begin rd = tsel[7:0]; held_d = 1'b0; end
          ADDR_TD1:  rd = tsel[15:8];
          ADDR_TD2:  begin rd = tod_q[23:16]; snap_d = tod_q; held_d = 1'b1; end
          ADDR_SDAT: rd = sdat_q;
          ADDR_ISR:  begin rd = isr_q; isr_d = '0; end
          ADDR_CA:   rd = ctrl_a_q;
          ADDR_CB:   rd = ctrl_b_q;
          default:   rd = '0;
        endcase
      end
      CMD_WRITE: begin
        case (item_i.reg_addr)
          ADDR_PA:   port_a_d = item_i.wdata;
          ADDR_PB:   port_b_d = item_i.wdata;
          ADDR_DA:   dir_a_d = item_i.wdata;
          ADDR_DB:   dir_b_d = item_i.wdata;
          ADDR_TAL:  rel_a_d[7:0] = item_i.wdata;
          ADDR_TAH:  begin
            rel_a_d[15:8] = item_i.wdata;
            if (!ctrl_a_q[0] || ctrl_a_q[3]) cnt_a_d = rel_a_d;
            if (ctrl_a_q[3]) ctrl_a_d[0] = 1'b1;
          end
          ADDR_TBL:  rel_b_d[7:0] = item_i.wdata;
          ADDR_TBH:  begin
            rel_b_d[15:8] = item_i.wdata;
            if (!ctrl_b_q[0] || ctrl_b_q[3]) cnt_b_d = rel_b_d;
            if (ctrl_b_q[3]) ctrl_b_d[0] = 1'b1;
          end
          ADDR_TD0: begin
            if (ctrl_b_q[7]) alarm_d[7:0] = item_i.wdata;
            else begin tod_d[7:0] = item_i.wdata; run_d = 1'b1; end
          end
          ADDR_TD1: begin
            if (ctrl_b_q[7]) alarm_d[15:8] = item_i.wdata;
            else begin tod_d[15:8] = item_i.wdata; run_d = 1'b0; end
          end
          ADDR_TD2: begin
            if (ctrl_b_q[7]) alarm_d[23:16] = item_i.wdata;
            else begin tod_d[23:16] = item_i.wdata; run_d = 1'b0; end
          end
          ADDR_SDAT: sdat_d = item_i.wdata;
          ADDR_ISR: begin
            if (item_i.wdata[7]) ien_d = ien_q | item_i.wdata[6:0];
            else ien_d = ien_q & ~item_i.wdata[6:0];
          end
          ADDR_CA: begin
            ctrl_a_d = item_i.wdata & 8'hEF;
            if (item_i.wdata[4]) cnt_a_d = rel_a_q;
          end
          ADDR_CB: begin
            ctrl_b_d = item_i.wdata & 8'hEF;
            if (item_i.wdata[4]) cnt_b_d = rel_b_q;
          end
          default: ;
        endcase
      end
      CMD_TIMER: begin
        // Count timer A, and timer B on clock or on A underflow
        if ((ctrl_a_q & 8'h21) == 8'h01) begin
          cnt_a_d = cnt_a_q - 16'd1;
          if (cnt_a_q == '0) begin
            und_a = 1'b1;
            if ((ctrl_b_q & 8'h61) == 8'h41) begin
              cnt_b_d = cnt_b_q - 16'd1;
              if (cnt_b_q == '0) und_b = 1'b1;
            end
          end
        end
        if ((ctrl_b_q & 8'h61) == 8'h01) begin
          cnt_b_d = cnt_b_q - 16'd1;
          if (cnt_b_q == '0) und_b = 1'b1;
        end
        if (und_a) begin
          setb[0] = 1'b1; cnt_a_d = rel_a_q;
          if (ctrl_a_q[3]) ctrl_a_d[0] = 1'b0;
        end
        if (und_b) begin
          setb[1] = 1'b1; cnt_b_d = rel_b_q;
          if (ctrl_b_q[3]) ctrl_b_d[0] = 1'b0;
        end
      end
      CMD_TOD: begin
        if (run_q) tod_d = tinc;
        if (tod_d == alarm_q) setb[2] = 1'b1;
      end
      CMD_FLAG:   setb[4] = 1'b1;
      CMD_SERIAL: begin sdat_d = item_i.wdata; setb[3] = 1'b1; end
      default: ;
    endcase
    // Merge newly set interrupt sources and recompute the summary bit
    isr_d[6:0] = isr_d[6:0] | setb;
    isr_d[7]   = |(ien_d & isr_d[6:0]);
    res_o.rdata = rd;
    res_o.irq   = isr_d[7];
  end

  // Hold state, advance on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_a_q <= '0; port_b_q <= '0; dir_a_q <= '0; dir_b_q <= '0;
      sdat_q <= '0; isr_q <= '0; ctrl_a_q <= CTRL_RESET; ctrl_b_q <= CTRL_RESET;
      cnt_a_q <= '1; cnt_b_q <= '1; rel_a_q <= '1; rel_b_q <= '1;
      tod_q <= '0; snap_q <= '0; alarm_q <= '0; held_q <= 1'b0; run_q <= 1'b0;
      ien_q <= '0;
    end else if (step_i) begin
      port_a_q <= port_a_d; port_b_q <= port_b_d; dir_a_q <= dir_a_d; dir_b_q <= dir_b_d;
      sdat_q <= sdat_d; isr_q <= isr_d; ctrl_a_q <= ctrl_a_d; ctrl_b_q <= ctrl_b_d;
      cnt_a_q <= cnt_a_d; cnt_b_q <= cnt_b_d; rel_a_q <= rel_a_d; rel_b_q <= rel_b_d;
      tod_q <= tod_d; snap_q <= snap_d; alarm_q <= alarm_d; held_q <= held_d;
      run_q <= run_d; ien_q <= ien_d;
    end
  end

endmodule

// File: rtl/cia_timer_tod_interrupt_unit.sv
// ----------------------------------------------------------------------------
// cia_timer_tod_interrupt_unit
// Timer, time-of-day and interrupt block with valid/ready channels.
// ----------------------------------------------------------------------------
// Each item is registered on acceptance, processed by the core once the
// result register is empty or being drained, and its result is placed in
// an output register; one item per clock is sustained while the output is
// not stalled, set by the single update pass of the register file.
module cia_timer_tod_interrupt_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cia_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cia_pkg::out_item_t out_data_o
);
  import cia_pkg::*;

  in_item_t  item_q;
  logic      item_vld_q;
  out_item_t res;
  logic      adv;

  // Advance when the result slot is empty or being drained
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = !item_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      item_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) item_q <= in_data_i;
  end

  cia_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (item_vld_q && adv),
    .item_i (item_q),
    .res_o  (res)
  );

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= item_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && item_vld_q) out_data_o <= res;
  end

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped while stalled");
  a_no_read_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_vld_q && adv && item_q.cmd != CMD_READ |=> out_data_o.rdata == '0)
    else $error("read data on non-read item");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_vld_q && adv |=> out_valid_o)
    else $error("processed item produced no result");
`endif

endmodule
